### hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character constants and helper functions for the string
// escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int MAX_RUN = 8;
    localparam int RUN_IDX_W = $clog2(MAX_RUN);
    localparam int RUN_LEN_W = $clog2(MAX_RUN + 1);

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CTRL_MAX       = 8'h1f;

    localparam logic [7:0] QUOTE_RESET  = 8'h22;
    localparam logic       QUOTED_RESET = 1'b1;

    typedef enum logic
    {
        CFG_QUOTE_BYTE  = 1'b0,
        CFG_QUOTED_MODE = 1'b1
    } cfg_index_t;

    // escaped run for one request, first byte in entry 0
    typedef struct packed
    {
        logic [MAX_RUN-1:0][7:0] data;
        logic [RUN_LEN_W-1:0]    len;
    } run_t;

    // second byte of a fixed two-byte escape, zero if the byte has none
    function automatic logic [7:0] two_byte_code(input logic [7:0] c);
        logic [7:0] code;
        begin
            case (c)
                8'h5c:   code = CHAR_BACKSLASH;
                8'h08:   code = 8'h62;
                8'h0c:   code = 8'h66;
                8'h0a:   code = 8'h6e;
                8'h0d:   code = 8'h72;
                8'h09:   code = 8'h74;
                default: code = 8'h00;
            endcase
            return code;
        end
    endfunction

    // lowercase hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        begin
            if (n < 4'd10)
            begin
                d = CHAR_ZERO + {4'd0, n};
            end
            else
            begin
                d = CHAR_A + {4'd0, n} - 8'd10;
            end
            return d;
        end
    endfunction

endpackage

### hw/rtl/jse_encode.sv
// ----------------------------------------------------------------------------
// jse_encode
// builds the escaped run of one request: optional open quote, the escape
// of the data byte, optional close quote
// ----------------------------------------------------------------------------
module jse_encode
(
    input  logic [7:0]    data_byte,
    input  logic          first_of_string,
    input  logic          last_of_string,
    input  logic          no_char,
    input  logic [7:0]    quote_byte,
    input  logic          quoted_mode,
    output jse_pkg::run_t run
);

    import jse_pkg::*;

    logic [MAX_RUN-1:0][7:0] esc;
    logic [RUN_LEN_W-1:0]    esc_len;
    logic [7:0]              two;
    logic                    open_q;
    logic                    close_q;

    always_comb
    begin
        logic [RUN_LEN_W-1:0] j;
        j       = '0;
        esc     = '0;
        esc_len = '0;
        two     = two_byte_code(data_byte);
        if (!no_char)
        begin
            // fixed escapes win over the quote test, quote over control bytes
            if (two != 8'h00)
            begin
                esc[0]  = CHAR_BACKSLASH;
                esc[1]  = two;
                esc_len = RUN_LEN_W'(2);
            end
            else if (data_byte == quote_byte)
            begin
                esc[0]  = CHAR_BACKSLASH;
                esc[1]  = quote_byte;
                esc_len = RUN_LEN_W'(2);
            end
            else if (data_byte <= CTRL_MAX)
            begin
                esc[0]  = CHAR_BACKSLASH;
                esc[1]  = CHAR_U;
                esc[2]  = CHAR_ZERO;
                esc[3]  = CHAR_ZERO;
                esc[4]  = hex_digit(data_byte[7:4]);
                esc[5]  = hex_digit(data_byte[3:0]);
                esc_len = RUN_LEN_W'(6);
            end
            else
            begin
                esc[0]  = data_byte;
                esc_len = RUN_LEN_W'(1);
            end
        end

        open_q  = quoted_mode && first_of_string;
        close_q = quoted_mode && last_of_string;

        run.len = RUN_LEN_W'(open_q) + esc_len + RUN_LEN_W'(close_q);
        for (int i = 0; i < MAX_RUN; i++)
        begin
            j = RUN_LEN_W'(i) - RUN_LEN_W'(open_q);
            if (open_q && (i == 0))
            begin
                run.data[i] = quote_byte;
            end
            else if (j < esc_len)
            begin
                run.data[i] = esc[j[RUN_IDX_W-1:0]];
            end
            else
            begin
                run.data[i] = quote_byte;
            end
        end
    end

endmodule

### hw/rtl/json_style_string_escaper_unit.sv
// ----------------------------------------------------------------------------
// json_style_string_escaper_unit
// escapes a byte stream JSON style, one escaped run per input request
// ----------------------------------------------------------------------------
// datapath: each byte moves from the run register through the output register
//   to m_tdata; one output byte per cycle while m_tready is high
// a request of n bytes holds the run register until its last byte is popped,
//   a request with an empty run is taken and dropped without output
// the run register and the output register decouple input and output
// reset: quote byte 0x22, quoted mode on, run and output registers empty
module json_style_string_escaper_unit
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [0] first_of_string, [1] no_char
    input  logic       s_tlast,   // last_of_string

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // last_of_run

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    import jse_pkg::*;

    logic [7:0]           quote_reg;
    logic                 quoted_reg;

    run_t                 new_run;
    run_t                 run_reg;
    logic                 run_valid_reg;
    logic [RUN_IDX_W-1:0] idx_reg;

    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_last_reg;

    logic                 out_load;
    logic                 pop;
    logic                 pop_last;
    logic                 s_take;

    jse_encode u_encode
    (
        .data_byte       (s_tdata),
        .first_of_string (s_tuser[0]),
        .last_of_string  (s_tlast),
        .no_char         (s_tuser[1]),
        .quote_byte      (quote_reg),
        .quoted_mode     (quoted_reg),
        .run             (new_run)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg  <= QUOTE_RESET;
            quoted_reg <= QUOTED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_QUOTE_BYTE:  quote_reg  <= cfg_data;
                CFG_QUOTED_MODE: quoted_reg <= cfg_data[0];
                default:         quote_reg  <= quote_reg;
            endcase
        end
    end

    assign out_load = !m_valid_reg || m_tready;
    assign pop      = run_valid_reg && out_load;
    assign pop_last = (RUN_LEN_W'(idx_reg) + RUN_LEN_W'(1)) == run_reg.len;
    assign s_tready = !run_valid_reg || (pop && pop_last);
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (s_take)
        begin
            // requests with an empty run are dropped here
            run_valid_reg <= (new_run.len != '0);
            idx_reg       <= '0;
        end
        else if (pop)
        begin
            run_valid_reg <= !pop_last;
            idx_reg       <= idx_reg + RUN_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            run_reg <= new_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= run_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_data_reg <= run_reg.data[idx_reg];
            m_last_reg <= pop_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // a held run is never empty and its pointer stays inside it
    a_run_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (run_reg.len != '0) && (RUN_LEN_W'(idx_reg) < run_reg.len))
        else $error("run register holds an empty run or pointer past its end");

    // a request with a nonempty run is held next cycle
    a_take_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s_take && (new_run.len != '0)) |=> run_valid_reg && (idx_reg == '0))
        else $error("accepted request was not captured");

    // the final byte of a run carries tlast
    a_last_marked : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_last) |=> m_tvalid && m_tlast)
        else $error("final byte of run missing tlast");

    // input is only taken when the run register is free or finishing
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (s_take && run_valid_reg) |-> (pop && pop_last))
        else $error("request accepted over an unfinished run");

endmodule
